[sv/cpcr_pkg.sv]
`timescale 1ns / 1ps

package cpcr_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int NW         = FRAC_BITS + 2;
	localparam int PW         = NW + 34 - FRAC_BITS;
	localparam int FW         = PW + NW - FRAC_BITS;
	localparam int SQ_STAGES  = 32;
	localparam int DIV_STAGES = 31;
	localparam int LANES      = 4;
	localparam int LN_NX      = 0;
	localparam int LN_NY      = 1;
	localparam int LN_OX      = 2;
	localparam int LN_OY      = 3;

	typedef struct packed {
		logic signed [31:0] first_pos_x;
		logic signed [31:0] first_pos_y;
		logic signed [31:0] first_vel_x;
		logic signed [31:0] first_vel_y;
		logic signed [31:0] second_pos_x;
		logic signed [31:0] second_pos_y;
		logic signed [31:0] second_vel_x;
		logic signed [31:0] second_vel_y;
		logic [30:0]        overlap_depth;
	} pair_t;

	typedef struct packed {
		logic signed [31:0] new_first_pos_x;
		logic signed [31:0] new_first_pos_y;
		logic signed [31:0] new_first_vel_x;
		logic signed [31:0] new_first_vel_y;
		logic signed [31:0] new_second_pos_x;
		logic signed [31:0] new_second_pos_y;
		logic signed [31:0] new_second_vel_x;
		logic signed [31:0] new_second_vel_y;
	} result_t;

	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		if (v > 40'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -40'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

[sv/cpcr_in_if.sv]
`timescale 1ns / 1ps

interface cpcr_in_if import cpcr_pkg::*; ();
	logic  valid;
	logic  ready;
	pair_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/cpcr_out_if.sv]
`timescale 1ns / 1ps

interface cpcr_out_if import cpcr_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[sv/circle_pair_collision_response.sv]
`timescale 1ns / 1ps

// Separates two overlapping circles and exchanges the normal component of their relative
// velocity, all in signed Q16.16. One pair enters per clock while no stall holds the pipeline;
// each result passes the front stages, the 32-stage bit-per-stage square root, the 31-stage
// shared-divisor long division that forms the unit normal and the push, then the back stages.
// Every stage has its own valid bit and stalls only when the stage ahead is full, so bubbles
// close up under backpressure. Pairs with coincident centres pass through unchanged.
module circle_pair_collision_response import cpcr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	cpcr_in_if.sink    pair,
	cpcr_out_if.source result
);

	localparam int ST_SQ0 = 7;
	localparam int ST_DV0 = ST_SQ0 + SQ_STAGES;
	localparam int ST_BK  = ST_DV0 + DIV_STAGES;
	localparam int NST    = ST_BK + 5;

	typedef struct packed {
		pair_t              orig;
		logic               zero;
		logic signed [32:0] rvx;
		logic signed [32:0] rvy;
	} ctx_t;

	typedef struct packed {
		logic [31:0] ax;
		logic [31:0] ay;
		logic [62:0] px;
		logic [62:0] py;
		logic        sx;
		logic        sy;
	} geo_t;

	typedef struct packed {
		logic [35:0] rem;
		logic [31:0] root;
		logic [63:0] s;
		geo_t        geo;
	} sq_t;

	typedef struct packed {
		logic [LANES-1:0][63:0] rem;
		logic [LANES-1:0][30:0] quo;
		logic [31:0]            d;
		logic                   sx;
		logic                   sy;
	} dv_t;

	logic [NST:1]   vld_q;
	logic [NST+1:1] en;
	ctx_t           ctx_s [1:NST];

	logic signed [32:0] ex_s1, ey_s1;
	logic signed [32:0] ex_s2, ey_s2;
	logic [32:0]        m_s2;
	logic               big_s2;
	logic [32:0]        ax2, ay2, hx, hy;
	logic [31:0]        sa, ta;
	logic [30:0]        ma;
	logic signed [31:0] exa_s3, eya_s3;
	logic [30:0]        ma_s3;
	logic               big_s3;
	logic [31:0]        sb, tb;
	logic [30:0]        mb;
	logic signed [31:0] exn_s4, eyn_s4;
	logic [31:0]        ax4, ay4;
	logic signed [63:0] sqx_s5, sqy_s5;
	geo_t               geo_s5, geo_s6;
	logic [63:0]        s_s6;

	sq_t sq_src [SQ_STAGES];
	sq_t sq_s   [SQ_STAGES];
	dv_t dv_src [DIV_STAGES];
	dv_t dv_s   [DIV_STAGES];

	logic signed [NW-1:0]    nx_s7, ny_s7, nx_s8, ny_s8, nx_s9, ny_s9;
	logic signed [31:0]      offx_s7, offy_s7, offx_s8, offy_s8, offx_s9, offy_s9;
	logic signed [31:0]      offx_s10, offy_s10, offx_s11, offy_s11;
	logic signed [NW+32:0]   prx_s8, pry_s8;
	logic signed [NW+33:0]   psum, pbias;
	logic signed [PW-1:0]    p_s9;
	logic signed [PW+NW-1:0] fmx_s10, fmy_s10, fbx, fby;
	logic signed [FW-1:0]    fx_s11, fy_s11;
	result_t                 out_s12;

	always_comb begin
		en[NST+1] = result.ready;
		for (int k = NST; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign pair.ready     = en[1];
	assign result.valid   = vld_q[NST];
	assign result.payload = out_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= pair.valid;
			end
			for (int k = 2; k <= NST; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// front: differences, magnitude, normalize, squares
	always_ff @(posedge clk) begin
		if (en[1]) begin
			ctx_s[1].orig <= pair.payload;
			ctx_s[1].zero <= (pair.payload.first_pos_x == pair.payload.second_pos_x) &&
				(pair.payload.first_pos_y == pair.payload.second_pos_y);
			ctx_s[1].rvx  <= 33'(pair.payload.first_vel_x) - 33'(pair.payload.second_vel_x);
			ctx_s[1].rvy  <= 33'(pair.payload.first_vel_y) - 33'(pair.payload.second_vel_y);
			ex_s1 <= 33'(pair.payload.first_pos_x) - 33'(pair.payload.second_pos_x);
			ey_s1 <= 33'(pair.payload.first_pos_y) - 33'(pair.payload.second_pos_y);
		end
	end

	for (genvar k = 2; k <= NST; k++) begin : g_ctx
		always_ff @(posedge clk) begin
			if (en[k]) begin
				ctx_s[k] <= ctx_s[k-1];
			end
		end
	end

	assign ax2 = ex_s1[32] ? 33'(-ex_s1) : 33'(ex_s1);
	assign ay2 = ey_s1[32] ? 33'(-ey_s1) : 33'(ey_s1);

	always_ff @(posedge clk) begin
		if (en[2]) begin
			ex_s2  <= ex_s1;
			ey_s2  <= ey_s1;
			m_s2   <= (ax2 > ay2) ? ax2 : ay2;
			big_s2 <= ((ax2 > ay2) ? (ax2[32] | ax2[31]) : (ay2[32] | ay2[31]));
		end
	end

	always_comb begin
		hx = ex_s2 + {32'b0, ex_s2[32]};
		hy = ey_s2 + {32'b0, ey_s2[32]};
		sa = ex_s2[31:0];
		ta = ey_s2[31:0];
		ma = m_s2[30:0];
		if (ma[30:15] == '0) begin
			sa = sa << 16;
			ta = ta << 16;
			ma = ma << 16;
		end
		if (ma[30:23] == '0) begin
			sa = sa << 8;
			ta = ta << 8;
			ma = ma << 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			exa_s3 <= big_s2 ? hx[32:1] : sa;
			eya_s3 <= big_s2 ? hy[32:1] : ta;
			ma_s3  <= ma;
			big_s3 <= big_s2;
		end
	end

	always_comb begin
		sb = exa_s3;
		tb = eya_s3;
		mb = ma_s3;
		if (!big_s3) begin
			if (mb[30:27] == '0) begin
				sb = sb << 4;
				tb = tb << 4;
				mb = mb << 4;
			end
			if (mb[30:29] == '0) begin
				sb = sb << 2;
				tb = tb << 2;
				mb = mb << 2;
			end
			if (!mb[30]) begin
				sb = sb << 1;
				tb = tb << 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			exn_s4 <= sb;
			eyn_s4 <= tb;
		end
	end

	assign ax4 = exn_s4[31] ? 32'(-exn_s4) : exn_s4;
	assign ay4 = eyn_s4[31] ? 32'(-eyn_s4) : eyn_s4;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			sqx_s5    <= exn_s4 * exn_s4;
			sqy_s5    <= eyn_s4 * eyn_s4;
			geo_s5.ax <= ax4;
			geo_s5.ay <= ay4;
			geo_s5.px <= {31'b0, ax4} * {32'b0, ctx_s[4].orig.overlap_depth};
			geo_s5.py <= {31'b0, ay4} * {32'b0, ctx_s[4].orig.overlap_depth};
			geo_s5.sx <= exn_s4[31];
			geo_s5.sy <= eyn_s4[31];
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			s_s6   <= 64'(sqx_s5) + 64'(sqy_s5);
			geo_s6 <= geo_s5;
		end
	end

	// square root, one result bit per stage
	for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sq
		localparam int I = SQ_STAGES - 1 - j;
		sq_t         nxt;
		logic [35:0] rin, trial;

		if (j == 0) begin : g_first
			assign sq_src[j] = '{rem: '0, root: '0, s: s_s6, geo: geo_s6};
		end else begin : g_next
			assign sq_src[j] = sq_s[j-1];
		end

		always_comb begin
			nxt   = sq_src[j];
			rin   = {sq_src[j].rem[33:0], sq_src[j].s[2*I+1 -: 2]};
			trial = {2'b00, sq_src[j].root, 2'b01};
			if (rin >= trial) begin
				nxt.rem  = rin - trial;
				nxt.root = {sq_src[j].root[30:0], 1'b1};
			end else begin
				nxt.rem  = rin;
				nxt.root = {sq_src[j].root[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_SQ0+j]) begin
				sq_s[j] <= nxt;
			end
		end
	end

	// long division of four lanes by d or 2d, one quotient bit per stage
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_dv
		localparam int I = DIV_STAGES - 1 - j;
		dv_t nxt;

		if (j == 0) begin : g_first
			always_comb begin
				dv_src[j].rem[LN_NX] = {32'b0, sq_s[SQ_STAGES-1].geo.ax} << FRAC_BITS;
				dv_src[j].rem[LN_NY] = {32'b0, sq_s[SQ_STAGES-1].geo.ay} << FRAC_BITS;
				dv_src[j].rem[LN_OX] = {1'b0, sq_s[SQ_STAGES-1].geo.px};
				dv_src[j].rem[LN_OY] = {1'b0, sq_s[SQ_STAGES-1].geo.py};
				dv_src[j].quo        = '0;
				dv_src[j].d          = sq_s[SQ_STAGES-1].root;
				dv_src[j].sx         = sq_s[SQ_STAGES-1].geo.sx;
				dv_src[j].sy         = sq_s[SQ_STAGES-1].geo.sy;
			end
		end else begin : g_next
			assign dv_src[j] = dv_s[j-1];
		end

		always_comb begin
			logic [63:0] dvs;
			logic        ge;
			nxt = dv_src[j];
			for (int l = 0; l < LANES; l++) begin
				if (l == LN_NX || l == LN_NY) begin
					dvs = {32'b0, dv_src[j].d};
				end else begin
					dvs = {31'b0, dv_src[j].d, 1'b0};
				end
				ge = (dv_src[j].rem[l] >> I) >= dvs;
				if (ge) begin
					nxt.rem[l] = dv_src[j].rem[l] - (dvs << I);
				end
				nxt.quo[l] = {dv_src[j].quo[l][29:0], ge};
			end
		end

		always_ff @(posedge clk) begin
			if (en[ST_DV0+j]) begin
				dv_s[j] <= nxt;
			end
		end
	end

	// back: signs, projection, saturated update
	always_ff @(posedge clk) begin
		if (en[ST_BK]) begin
			nx_s7 <= dv_s[DIV_STAGES-1].sx ?
				-$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_NX][NW-2:0]}) :
				$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_NX][NW-2:0]});
			ny_s7 <= dv_s[DIV_STAGES-1].sy ?
				-$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_NY][NW-2:0]}) :
				$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_NY][NW-2:0]});
			offx_s7 <= dv_s[DIV_STAGES-1].sx ?
				-$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_OX]}) :
				$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_OX]});
			offy_s7 <= dv_s[DIV_STAGES-1].sy ?
				-$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_OY]}) :
				$signed({1'b0, dv_s[DIV_STAGES-1].quo[LN_OY]});
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_BK+1]) begin
			prx_s8  <= ctx_s[ST_BK].rvx * nx_s7;
			pry_s8  <= ctx_s[ST_BK].rvy * ny_s7;
			nx_s8   <= nx_s7;
			ny_s8   <= ny_s7;
			offx_s8 <= offx_s7;
			offy_s8 <= offy_s7;
		end
	end

	assign psum  = prx_s8 + pry_s8;
	assign pbias = psum + $signed({{(NW+34-FRAC_BITS){1'b0}}, {FRAC_BITS{psum[NW+33]}}});

	always_ff @(posedge clk) begin
		if (en[ST_BK+2]) begin
			p_s9    <= pbias[NW+33:FRAC_BITS];
			nx_s9   <= nx_s8;
			ny_s9   <= ny_s8;
			offx_s9 <= offx_s8;
			offy_s9 <= offy_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_BK+3]) begin
			fmx_s10  <= p_s9 * nx_s9;
			fmy_s10  <= p_s9 * ny_s9;
			offx_s10 <= offx_s9;
			offy_s10 <= offy_s9;
		end
	end

	assign fbx = fmx_s10 + $signed({{(PW+NW-FRAC_BITS){1'b0}}, {FRAC_BITS{fmx_s10[PW+NW-1]}}});
	assign fby = fmy_s10 + $signed({{(PW+NW-FRAC_BITS){1'b0}}, {FRAC_BITS{fmy_s10[PW+NW-1]}}});

	always_ff @(posedge clk) begin
		if (en[ST_BK+4]) begin
			fx_s11   <= fbx[PW+NW-1:FRAC_BITS];
			fy_s11   <= fby[PW+NW-1:FRAC_BITS];
			offx_s11 <= offx_s10;
			offy_s11 <= offy_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			if (ctx_s[NST-1].zero) begin
				out_s12.new_first_pos_x  <= ctx_s[NST-1].orig.first_pos_x;
				out_s12.new_first_pos_y  <= ctx_s[NST-1].orig.first_pos_y;
				out_s12.new_first_vel_x  <= ctx_s[NST-1].orig.first_vel_x;
				out_s12.new_first_vel_y  <= ctx_s[NST-1].orig.first_vel_y;
				out_s12.new_second_pos_x <= ctx_s[NST-1].orig.second_pos_x;
				out_s12.new_second_pos_y <= ctx_s[NST-1].orig.second_pos_y;
				out_s12.new_second_vel_x <= ctx_s[NST-1].orig.second_vel_x;
				out_s12.new_second_vel_y <= ctx_s[NST-1].orig.second_vel_y;
			end else begin
				out_s12.new_first_pos_x  <= sat32(40'(ctx_s[NST-1].orig.first_pos_x) +
					40'(offx_s11));
				out_s12.new_first_pos_y  <= sat32(40'(ctx_s[NST-1].orig.first_pos_y) +
					40'(offy_s11));
				out_s12.new_first_vel_x  <= sat32(40'(ctx_s[NST-1].orig.first_vel_x) -
					40'(fx_s11));
				out_s12.new_first_vel_y  <= sat32(40'(ctx_s[NST-1].orig.first_vel_y) -
					40'(fy_s11));
				out_s12.new_second_pos_x <= sat32(40'(ctx_s[NST-1].orig.second_pos_x) -
					40'(offx_s11));
				out_s12.new_second_pos_y <= sat32(40'(ctx_s[NST-1].orig.second_pos_y) -
					40'(offy_s11));
				out_s12.new_second_vel_x <= sat32(40'(ctx_s[NST-1].orig.second_vel_x) +
					40'(fx_s11));
				out_s12.new_second_vel_y <= sat32(40'(ctx_s[NST-1].orig.second_vel_y) +
					40'(fy_s11));
			end
		end
	end

`ifndef SYNTH
	a_fill_rate: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_q) <= $past($countones(vld_q)) + 1)
		else $error("pipeline gained more than one beat in a cycle");

	a_root_norm: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ST_DV0-1] && !ctx_s[ST_DV0-1].zero |-> sq_s[SQ_STAGES-1].root[31:30] != 2'b00)
		else $error("normalized distance below range");

	a_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && ctx_s[NST].zero |->
			result.payload.new_first_vel_x == ctx_s[NST].orig.first_vel_x &&
			result.payload.new_second_pos_y == ctx_s[NST].orig.second_pos_y)
		else $error("coincident pair altered");
`endif

endmodule

[dv/tb_circle_pair_collision_response.sv]
`timescale 1ns / 1ps

module tb_circle_pair_collision_response;
	import cpcr_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 150;
	localparam int MAX_GAP        = 17;

	logic clk;
	logic arst_n;
	cpcr_in_if  pin ();
	cpcr_out_if pout ();

	circle_pair_collision_response uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pair   (pin),
		.result (pout)
	);

	result_t expected_results[$];
	int      mismatches;
	int      stall_cycles;
	bit      calm;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic longint unsigned floor_root(longint unsigned s);
		longint unsigned root;
		longint unsigned bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= root + bitv) begin
				s -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic result_t collide_pair(pair_t p);
		longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dep;
		longint ex, ey, ax, ay, m, d, offx, offy, nx, ny, pr, fx, fy;
		longint unsigned s;
		result_t r;
		x1  = p.first_pos_x;   y1  = p.first_pos_y;
		vx1 = p.first_vel_x;   vy1 = p.first_vel_y;
		x2  = p.second_pos_x;  y2  = p.second_pos_y;
		vx2 = p.second_vel_x;  vy2 = p.second_vel_y;
		dep = longint'({33'd0, p.overlap_depth});
		ex = x1 - x2;
		ey = y1 - y2;
		if (ex == 0 && ey == 0) begin
			r = '{p.first_pos_x, p.first_pos_y, p.first_vel_x, p.first_vel_y,
				p.second_pos_x, p.second_pos_y, p.second_vel_x, p.second_vel_y};
			return r;
		end
		ax = ex < 0 ? -ex : ex;
		ay = ey < 0 ? -ey : ey;
		m = ax > ay ? ax : ay;
		if (m >= (64'sd1 <<< 31)) begin
			ex = ex / 2;
			ey = ey / 2;
		end else begin
			while (m < (64'sd1 <<< 30)) begin
				ex = ex * 2;
				ey = ey * 2;
				m = m * 2;
			end
		end
		s = longint'(ex * ex) + longint'(ey * ey);
		d = longint'(floor_root(s));
		offx = (ex * dep) / (2 * d);
		offy = (ey * dep) / (2 * d);
		nx = (ex * (64'sd1 <<< FRAC_BITS)) / d;
		ny = (ey * (64'sd1 <<< FRAC_BITS)) / d;
		pr = ((vx1 - vx2) * nx + (vy1 - vy2) * ny) / (64'sd1 <<< FRAC_BITS);
		fx = (pr * nx) / (64'sd1 <<< FRAC_BITS);
		fy = (pr * ny) / (64'sd1 <<< FRAC_BITS);
		r.new_first_pos_x  = clamp32(x1 + offx);
		r.new_first_pos_y  = clamp32(y1 + offy);
		r.new_first_vel_x  = clamp32(vx1 - fx);
		r.new_first_vel_y  = clamp32(vy1 - fy);
		r.new_second_pos_x = clamp32(x2 - offx);
		r.new_second_pos_y = clamp32(y2 - offy);
		r.new_second_vel_x = clamp32(vx2 + fx);
		r.new_second_vel_y = clamp32(vy2 + fy);
		return r;
	endfunction

	function automatic pair_t make_pair(int x1, int y1, int vx1, int vy1,
		int x2, int y2, int vx2, int vy2, int dep);
		pair_t p;
		p = '{x1, y1, vx1, vy1, x2, y2, vx2, vy2, dep[30:0]};
		return p;
	endfunction

	function automatic int near_value(int base);
		int span;
		span = 1 << $urandom_range(0, 24);
		return base + $signed($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic pair_t random_pair();
		pair_t p;
		p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, 31'($urandom)};
		case ($urandom_range(0, 5))
			0: ;
			1: begin
				p.second_pos_x = p.first_pos_x;
				p.second_pos_y = p.first_pos_y;
			end
			2: begin
				p.second_pos_x = near_value(p.first_pos_x);
				p.second_pos_y = p.first_pos_y;
			end
			default: begin
				p.second_pos_x = near_value(p.first_pos_x);
				p.second_pos_y = near_value(p.first_pos_y);
				if ($urandom_range(0, 1)) begin
					p.overlap_depth = 31'($urandom_range(0, 32'h0008_0000));
				end
			end
		endcase
		return p;
	endfunction

	task automatic send_pair(pair_t p);
		int gap;
		gap = calm ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			pin.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pin.valid   <= 1'b1;
		pin.payload <= p;
		do @(posedge clk); while (!pin.ready);
		expected_results.insert(expected_results.size(), collide_pair(p));
	endtask

	task automatic wait_drained();
		pin.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	task automatic test_coincident();
		send_pair(make_pair(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, -32'h0001_0000,
			32'h0001_0000, 32'h0002_0000, -32'h0004_0000, 32'h0000_8000, 32'h7fff_ffff));
		send_pair(make_pair(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
			32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0));
	endtask

	task automatic test_axes();
		send_pair(make_pair(32'h0001_0000, 0, -32'h0001_0000, 0, 0, 0, 32'h0001_0000, 0,
			32'h0000_8000));
		send_pair(make_pair(0, -32'h0003_0000, 0, 32'h0002_0000, 0, 0, 0, -32'h0002_0000,
			32'h0001_0000));
		send_pair(make_pair(1, 1, 32'h0005_0000, -32'h0005_0000, 0, 0, 0, 0, 32'h0001_0000));
		send_pair(make_pair(0, 0, 0, 0, 1, 0, 0, 0, 0));
		send_pair(make_pair(-1, 0, 32'h7fff_ffff, 32'h8000_0000, 0, -1, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff));
		send_pair(make_pair(32'h0003_0000, 32'h0004_0000, 32'h1234_5678, -32'h0765_4321,
			0, 0, -32'h0100_0000, 32'h0200_0000, 32'h0002_0000));
	endtask

	task automatic test_extremes();
		send_pair(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff));
		send_pair(make_pair(32'h8000_0000, 0, 32'h8000_0000, 0,
			32'h7fff_ffff, 0, 32'h7fff_ffff, 0, 32'h7fff_ffff));
		send_pair(make_pair(32'h7fff_fff0, 32'h8000_0010, 0, 0,
			32'h7fff_ffe0, 32'h8000_0020, 0, 0, 32'h7fff_ffff));
		send_pair(make_pair(0, 32'h7fff_ffff, 32'h4000_0000, 32'h7fff_ffff,
			0, 32'h8000_0000, -32'h4000_0000, 32'h8000_0000, 0));
		send_pair(make_pair(32'h4000_0000, -32'h4000_0000, 0, 0,
			-32'h4000_0000, 32'h4000_0000, 0, 0, 32'h5555_5555));
	endtask

	task automatic test_drain_pause();
		repeat (20) send_pair(random_pair());
		wait_drained();
		repeat (10) send_pair(random_pair());
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
			send_pair(random_pair());
		end
		calm = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		pin.valid    = 1'b0;
		pin.payload  = '0;
		pout.ready   = 1'b0;
		calm         = 1'b0;
		mismatches   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_coincident();
		test_axes();
		test_extremes();
		test_drain_pause();
		test_random(570);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		int hold;
		@(posedge arst_n);
		forever begin
			hold = calm ? 0 : $urandom_range(0, MAX_GAP);
			if (hold > 0) begin
				pout.ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pout.ready <= 1'b1;
			do @(posedge clk); while (!pout.valid);
		end
	end

	always @(posedge clk) begin
		logic [7:0][31:0] want;
		logic [7:0][31:0] got;
		if (arst_n && pout.valid && pout.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat: %h", pout.payload);
			end else begin
				want = expected_results.pop_front();
				got  = pout.payload;
				for (int f = 7; f >= 0; f--) begin
					if (want[f] !== got[f]) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("field %0d: expected %h, got %h", 7 - f, want[f], got[f]);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (pin.valid && pin.ready) || (pout.valid && pout.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule
